@@ src/pspt_pkg.sv @@
// Shared codes, widths and types of the PCM stream playback tracker.
`default_nettype none

package pspt_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned QUEUE_FRAMES_DFLT  = 4096;
  localparam int unsigned PACKET_FRAMES_DFLT = 256;
  localparam int unsigned SEGMENTS_DFLT      = 8;

  // Fixed field widths
  localparam int unsigned POS_W    = 48;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned FRAMES_W = 9;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STAT_W   = 2;

  localparam logic [LEN_W-1:0] PERIOD_RST = LEN_W'(256);

  // Command codes
  localparam logic [FUNC_W-1:0] FN_OPEN     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DATA     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FINISH   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CANCEL   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SUBMIT   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_PROGRESS = 3'd6;

  // Stream modes
  localparam logic [MODE_W-1:0] MD_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MD_ACCEPTING = 3'd1;
  localparam logic [MODE_W-1:0] MD_FINISHING = 3'd2;
  localparam logic [MODE_W-1:0] MD_DRAINED   = 3'd3;
  localparam logic [MODE_W-1:0] MD_CANCELLED = 3'd4;
  localparam logic [MODE_W-1:0] MD_FAILED    = 3'd5;

  // Result status
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  // One stored segment
  typedef struct packed {
    logic [POS_W-1:0] hw_first;
    logic [POS_W-1:0] strm_base;
    logic [LEN_W-1:0] length;
  } seg_t;

  // Evaluation of one segment against the play position
  typedef struct packed {
    logic [LEN_W-1:0] count;
    logic             done;
  } cnt_t;

endpackage

`default_nettype wire

@@ src/pspt_seg_ram.sv @@
// Segment store: one write port, one registered read port.
`default_nettype none

module pspt_seg_ram import pspt_pkg::*; #(
  parameter int unsigned DEPTH = SEGMENTS_DFLT,
  parameter int unsigned AW    = 3
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire seg_t          wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output seg_t               rdata_o
);

  seg_t mem [DEPTH];
  seg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/pspt_seg_eval.sv @@
// Frames of one segment covered by the hardware play position.
`default_nettype none

module pspt_seg_eval import pspt_pkg::*; (
  input  wire logic [POS_W-1:0] hw_i,
  input  wire seg_t             seg_i,
  output cnt_t                  cnt_o
);

  logic [POS_W:0]   diff;
  logic [LEN_W-1:0] count;

  // Clamp hw - first to [0, length]
  always_comb begin
    diff = {1'b0, hw_i} - {1'b0, seg_i.hw_first};
    if (diff[POS_W] || diff == '0) begin
      count = '0;
    end else if (diff[POS_W-1:0] > POS_W'(seg_i.length)) begin
      count = seg_i.length;
    end else begin
      count = diff[LEN_W-1:0];
    end
  end

  assign cnt_o.count = count;
  assign cnt_o.done  = (count == seg_i.length);

endmodule

`default_nettype wire

@@ src/pcm_stream_playback_tracker.sv @@
// A message or submit word runs ST_EXEC, then ST_OUT loads its result into the output register
//   once it is free. Progress runs ST_RD, ST_CNT, ST_ACC per segment via the registered read
//   port until the store is empty or a segment is not done, then ST_PFIN and ST_OUT.
// Throughput: one word in flight; the next word is taken once the result reaches the
//   output register, even while that result still waits for out_ready_i.
// Reset: asynchronous, clears mode, counters and segment pointers; period returns to 256.
`default_nettype none

module pcm_stream_playback_tracker import pspt_pkg::*; #(
  parameter int unsigned QUEUE_FRAMES  = QUEUE_FRAMES_DFLT,
  parameter int unsigned PACKET_FRAMES = PACKET_FRAMES_DFLT,
  parameter int unsigned SEGMENTS      = SEGMENTS_DFLT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel (period)
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [LEN_W-1:0]    cfg_data_i,
  // input word channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [FRAMES_W-1:0] frame_count_i,
  input  wire logic [POS_W-1:0]    hw_position_i,
  // result word channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic [MODE_W-1:0]        stream_state_o,
  output logic [LEN_W-1:0]         issued_frames_o,
  output logic [POS_W-1:0]         accepted_count_o,
  output logic [POS_W-1:0]         played_count_o
);

  localparam int unsigned Q_W    = $clog2(QUEUE_FRAMES + 1);
  localparam int unsigned QP_W   = (Q_W > LEN_W) ? Q_W : LEN_W;
  localparam int unsigned SEG_IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned SEG_CW = $clog2(SEGMENTS + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a word
  localparam logic [2:0] ST_EXEC = 3'd1;  // run message or submit
  localparam logic [2:0] ST_RD   = 3'd2;  // issue read of oldest segment
  localparam logic [2:0] ST_CNT  = 3'd3;  // clamp covered frames
  localparam logic [2:0] ST_ACC  = 3'd4;  // advance played, retire segment
  localparam logic [2:0] ST_PFIN = 3'd5;  // drained check after the walk
  localparam logic [2:0] ST_OUT  = 3'd6;  // hand result to output register

  logic [2:0]          st_q, st_d;
  logic [LEN_W-1:0]    period_q;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [Q_W-1:0]      queued_q, queued_d;
  logic [POS_W-1:0]    acc_q, acc_d;
  logic [POS_W-1:0]    sub_q, sub_d;
  logic [POS_W-1:0]    played_q, played_d;
  logic [SEG_IW-1:0]   head_q, head_d;
  logic [SEG_CW-1:0]   used_q, used_d;

  // Captured word and per-item results (payload)
  logic [FUNC_W-1:0]   func_q;
  logic [FRAMES_W-1:0] frames_q;
  logic [POS_W-1:0]    hw_q;
  logic [STAT_W-1:0]   status_q, status_d;
  logic [LEN_W-1:0]    issued_q, issued_d;

  // Walk stage registers
  logic [LEN_W-1:0]    cnt_q;
  logic [POS_W-1:0]    sf_q;
  logic                done_q;

  logic                out_valid_q;
  logic                out_load;
  logic                in_take;

  // Segment store ports
  logic                wr_en, rd_en;
  logic [SEG_IW-1:0]   tail;
  seg_t                wr_seg, rd_seg;
  cnt_t                eval;

  // Datapath helpers
  logic [LEN_W-1:0]    ready_n;
  logic [QP_W-1:0]     queued_ext;
  logic [Q_W:0]        room_sum;
  logic [POS_W:0]      acc_sum;
  logic [SEG_IW:0]     tail_sum;
  logic [POS_W-1:0]    reach;
  logic                is_live;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign out_load    = (st_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Frames one submit would take: a full period, or the remainder while finishing
  assign is_live    = (mode_q == MD_ACCEPTING) || (mode_q == MD_FINISHING);
  assign queued_ext = QP_W'(queued_q);
  always_comb begin
    ready_n = '0;
    if (is_live) begin
      if (queued_ext >= QP_W'(period_q)) begin
        ready_n = period_q;
      end else if (mode_q == MD_FINISHING) begin
        ready_n = LEN_W'(queued_ext);
      end
    end
  end

  // Queue room and 48-bit overflow for a data word
  assign room_sum = {1'b0, queued_q} + (Q_W+1)'(frames_q);
  assign acc_sum  = {1'b0, acc_q} + (POS_W+1)'(frames_q);

  // Append point of the circular segment store
  assign tail_sum = (SEG_IW+1)'(head_q) + (SEG_IW+1)'(used_q);
  assign tail     = (tail_sum >= (SEG_IW+1)'(SEGMENTS)) ?
                    SEG_IW'(tail_sum - (SEG_IW+1)'(SEGMENTS)) : SEG_IW'(tail_sum);

  assign wr_seg.hw_first  = hw_q;
  assign wr_seg.strm_base = sub_q;
  assign wr_seg.length    = ready_n;

  assign reach = sf_q + POS_W'(cnt_q);

  pspt_seg_ram #(
    .DEPTH (SEGMENTS),
    .AW    (SEG_IW)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail),
    .wdata_i (wr_seg),
    .re_i    (rd_en),
    .raddr_i (head_q),
    .rdata_o (rd_seg)
  );

  pspt_seg_eval u_seg_eval (
    .hw_i  (hw_q),
    .seg_i (rd_seg),
    .cnt_o (eval)
  );

  // Sequencer and stream state update
  always_comb begin
    st_d     = st_q;
    mode_d   = mode_q;
    queued_d = queued_q;
    acc_d    = acc_q;
    sub_d    = sub_q;
    played_d = played_q;
    head_d   = head_q;
    used_d   = used_q;
    status_d = status_q;
    issued_d = issued_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          st_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        status_d = STAT_OK;
        issued_d = '0;
        st_d     = ST_OUT;
        unique case (func_q)
          FN_SUBMIT: begin
            if (ready_n != '0) begin
              if (used_q == SEG_CW'(SEGMENTS)) begin
                // store full: fail the stream, drop what is queued
                mode_d   = MD_FAILED;
                queued_d = '0;
                status_d = STAT_OVERFLOW;
              end else begin
                wr_en    = 1'b1;
                used_d   = used_q + 1'b1;
                sub_d    = sub_q + POS_W'(ready_n);
                queued_d = queued_q - Q_W'(ready_n);
                issued_d = ready_n;
              end
            end
          end
          FN_PROGRESS: begin
            st_d = ST_RD;
          end
          FN_OPEN: begin
            if (mode_q != MD_IDLE || frames_q != '0) begin
              status_d = STAT_REJECT;
            end else begin
              mode_d = MD_ACCEPTING;
            end
          end
          FN_DATA: begin
            if (mode_q != MD_ACCEPTING || frames_q == '0 ||
                LEN_W'(frames_q) > LEN_W'(PACKET_FRAMES) ||
                room_sum > (Q_W+1)'(QUEUE_FRAMES) || acc_sum[POS_W]) begin
              status_d = STAT_REJECT;
            end else begin
              queued_d = room_sum[Q_W-1:0];
              acc_d    = acc_sum[POS_W-1:0];
            end
          end
          FN_FINISH: begin
            if (frames_q != '0 || !is_live) begin
              status_d = STAT_REJECT;
            end else begin
              mode_d = (played_q == acc_q) ? MD_DRAINED : MD_FINISHING;
            end
          end
          FN_CANCEL: begin
            if (mode_q == MD_IDLE || frames_q != '0) begin
              status_d = STAT_REJECT;
            end else begin
              mode_d   = MD_CANCELLED;
              queued_d = '0;
            end
          end
          FN_QUERY: begin
            if (mode_q == MD_IDLE || frames_q != '0) begin
              status_d = STAT_REJECT;
            end
          end
          default: begin
            status_d = STAT_REJECT;
          end
        endcase
      end

      ST_RD: begin
        // walk ends when the store is empty
        if (used_q == '0) begin
          st_d = ST_PFIN;
        end else begin
          rd_en = 1'b1;
          st_d  = ST_CNT;
        end
      end

      ST_CNT: begin
        st_d = ST_ACC;
      end

      ST_ACC: begin
        if (cnt_q != '0 && reach > played_q) begin
          played_d = reach;
        end
        if (done_q) begin
          // retire the oldest segment and look at the next one
          head_d = (head_q == SEG_IW'(SEGMENTS - 1)) ? '0 : head_q + 1'b1;
          used_d = used_q - 1'b1;
          st_d   = ST_RD;
        end else begin
          st_d = ST_PFIN;
        end
      end

      ST_PFIN: begin
        if (mode_q == MD_FINISHING && played_q == acc_q) begin
          mode_d = MD_DRAINED;
        end
        st_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_load) begin
          st_d = ST_IDLE;
          // a rejected word clears the stream once its result is out
          if (status_q == STAT_REJECT) begin
            mode_d   = MD_IDLE;
            queued_d = '0;
            acc_d    = '0;
            sub_d    = '0;
            played_d = '0;
            head_d   = '0;
            used_d   = '0;
          end
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      period_q    <= PERIOD_RST;
      mode_q      <= MD_IDLE;
      queued_q    <= '0;
      acc_q       <= '0;
      sub_q       <= '0;
      played_q    <= '0;
      head_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      mode_q   <= mode_d;
      queued_q <= queued_d;
      acc_q    <= acc_d;
      sub_q    <= sub_d;
      played_q <= played_d;
      head_q   <= head_d;
      used_q   <= used_d;
      if (cfg_valid_i) begin
        period_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: captured word, walk stage, result word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q   <= func_i;
      frames_q <= frame_count_i;
      hw_q     <= hw_position_i;
    end
    status_q <= status_d;
    issued_q <= issued_d;
    if (st_q == ST_CNT) begin
      cnt_q  <= eval.count;
      sf_q   <= rd_seg.strm_base;
      done_q <= eval.done;
    end
    if (out_load) begin
      status_o         <= status_q;
      stream_state_o   <= (status_q == STAT_REJECT) ? MD_FAILED : mode_q;
      issued_frames_o  <= issued_q;
      accepted_count_o <= acc_q;
      played_count_o   <= played_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Segment count never passes the store depth
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SEG_CW'(SEGMENTS))
    else $error("segment count above store depth");

  // Queue never holds more than its capacity
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_q <= Q_W'(QUEUE_FRAMES))
    else $error("queue above capacity");

  // A rejected word leaves a cleared stream behind
  a_reject_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_q == STAT_REJECT) |=>
      (mode_q == MD_IDLE && used_q == '0 && acc_q == '0 && played_q == '0))
    else $error("stream not cleared after rejection");

  // Store overflow always reports a failed stream
  a_ovf_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_OVERFLOW) |-> stream_state_o == MD_FAILED)
    else $error("overflow without failed state");

  // Frames are issued only by a successful word
  a_issue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && issued_frames_o != '0) |-> status_o == STAT_OK)
    else $error("frames issued with error status");

endmodule

`default_nettype wire

@@ dv/pcm_stream_playback_tracker_tb.sv @@
// Self-checking testbench for the PCM stream playback tracker: scoreboard class plus top.
`timescale 1ns / 100ps

import pspt_pkg::*;

// One result word as the block reports it
typedef struct packed {
  logic [STAT_W-1:0] status;
  logic [MODE_W-1:0] state;
  logic [LEN_W-1:0]  issued;
  logic [POS_W-1:0]  accepted;
  logic [POS_W-1:0]  played;
} stream_report_t;

class stream_scoreboard;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic [LEN_W-1:0]  period;
  logic [MODE_W-1:0] mode;
  int unsigned       queued;
  logic [POS_W-1:0]  accepted;
  logic [POS_W-1:0]  submitted;
  logic [POS_W-1:0]  played;
  logic [POS_W-1:0]  seg_hw[SEGMENTS_DFLT];
  logic [POS_W-1:0]  seg_stream[SEGMENTS_DFLT];
  logic [LEN_W-1:0]  seg_len[SEGMENTS_DFLT];
  int unsigned       seg_used;
  int unsigned       last_issued;
  int unsigned       mismatches;
  stream_report_t    pending_reports[$];

  function new();
    period      = PERIOD_RST;
    mismatches  = 0;
    last_issued = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    mode      = MD_IDLE;
    queued    = 0;
    accepted  = '0;
    submitted = '0;
    played    = '0;
    seg_used  = 0;
    for (int k = 0; k < SEGMENTS_DFLT; k++) begin
      seg_hw[k]     = '0;
      seg_stream[k] = '0;
      seg_len[k]    = '0;
    end
  endfunction

  function int unsigned pending();
    return pending_reports.size();
  endfunction

  task note_mismatch(string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Protocol messages; returns 0 when the word is rejected
  function bit apply_message(logic [FUNC_W-1:0] fn, logic [FRAMES_W-1:0] frames);
    if (fn == FN_OPEN) begin
      if (mode != MD_IDLE || frames != 0) return 0;
      mode = MD_ACCEPTING;
      return 1;
    end
    if (mode == MD_IDLE) return 0;
    if (fn == FN_DATA) begin
      if (mode != MD_ACCEPTING || frames == 0 || frames > PACKET_FRAMES_DFLT) return 0;
      if (queued > QUEUE_FRAMES_DFLT || frames > QUEUE_FRAMES_DFLT - queued) return 0;
      if (accepted > POS_MAX - POS_W'(frames)) return 0;
      queued   += frames;
      accepted += POS_W'(frames);
      return 1;
    end
    if (frames != 0) return 0;
    if (fn == FN_FINISH) begin
      if (mode != MD_ACCEPTING && mode != MD_FINISHING) return 0;
      mode = (played == accepted) ? MD_DRAINED : MD_FINISHING;
      return 1;
    end
    if (fn == FN_CANCEL) begin
      mode   = MD_CANCELLED;
      queued = 0;
      return 1;
    end
    if (fn == FN_QUERY) return 1;
    return 0;
  endfunction

  // Frames one submit would move into a segment right now
  function int unsigned submit_size();
    if (mode != MD_ACCEPTING && mode != MD_FINISHING) return 0;
    if (queued >= period) return period;
    return (mode == MD_FINISHING) ? queued : 0;
  endfunction

  // Walk segments from the oldest against the hardware played count
  function void retire_played(logic [POS_W-1:0] hw);
    int unsigned      done;
    logic [POS_W-1:0] cnt;
    logic [POS_W-1:0] reach;
    done = 0;
    for (int j = 0; j < seg_used; j++) begin
      cnt = (hw > seg_hw[j]) ? hw - seg_hw[j] : '0;
      if (cnt > POS_W'(seg_len[j])) cnt = POS_W'(seg_len[j]);
      reach = seg_stream[j] + cnt;
      if (cnt != 0 && reach > played) played = reach;
      if (cnt == POS_W'(seg_len[j])) done++;
      else break;
    end
    if (done != 0) begin
      for (int k = 0; k + done < seg_used; k++) begin
        seg_hw[k]     = seg_hw[k + done];
        seg_stream[k] = seg_stream[k + done];
        seg_len[k]    = seg_len[k + done];
      end
      seg_used -= done;
    end
    if (mode == MD_FINISHING && played == accepted) mode = MD_DRAINED;
  endfunction

  function stream_report_t step_stream(logic [FUNC_W-1:0] fn, logic [FRAMES_W-1:0] frames,
                                       logic [POS_W-1:0] hw);
    stream_report_t r;
    int unsigned    n;
    r = '0;
    if (fn == FN_SUBMIT) begin
      n = submit_size();
      if (n != 0) begin
        if (seg_used >= SEGMENTS_DFLT) begin
          mode     = MD_FAILED;
          queued   = 0;
          r.status = STAT_OVERFLOW;
        end else begin
          seg_hw[seg_used]     = hw;
          seg_stream[seg_used] = submitted;
          seg_len[seg_used]    = LEN_W'(n);
          seg_used++;
          submitted += POS_W'(n);
          queued    -= n;
          r.issued   = LEN_W'(n);
        end
      end
    end else if (fn == FN_PROGRESS) begin
      retire_played(hw);
    end else if (!apply_message(fn, frames)) begin
      r.status = STAT_REJECT;
    end
    r.state    = (r.status == STAT_REJECT) ? MD_FAILED : mode;
    r.accepted = accepted;
    r.played   = played;
    if (r.status == STAT_REJECT) clear_stream();
    last_issued = r.issued;
    return r;
  endfunction

  function void log_command(logic [FUNC_W-1:0] fn, logic [FRAMES_W-1:0] frames,
                            logic [POS_W-1:0] hw);
    pending_reports.push_back(step_stream(fn, frames, hw));
  endfunction

  task check_report(stream_report_t got);
    stream_report_t want;
    if (pending_reports.size() == 0) begin
      note_mismatch("result word with no command waiting");
      return;
    end
    want = pending_reports.pop_front();
    if (got.status != want.status)
      note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.state != want.state)
      note_mismatch($sformatf("stream_state %0d, want %0d", got.state, want.state));
    if (got.issued != want.issued)
      note_mismatch($sformatf("issued_frames %0d, want %0d", got.issued, want.issued));
    if (got.accepted != want.accepted)
      note_mismatch($sformatf("accepted_count %0d, want %0d", got.accepted, want.accepted));
    if (got.played != want.played)
      note_mismatch($sformatf("played_count %0d, want %0d", got.played, want.played));
  endtask
endclass

module pcm_stream_playback_tracker_tb;

  // Func code 7 has no meaning; the block must reject it
  localparam logic [FUNC_W-1:0] FN_UNUSED      = 3'd7;
  localparam logic [POS_W-1:0]  POS_MAX        = '1;
  localparam int                WATCHDOG_LIMIT = 2000;
  // Longest progress walk examines all 8 segments; give it room
  localparam int                SETTLE_CYCLES  = 40;
  localparam int                PHASE_WORDS    = 225;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LEN_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i;
  logic [FRAMES_W-1:0] frame_count_i;
  logic [POS_W-1:0]    hw_position_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STAT_W-1:0]   status_o;
  logic [MODE_W-1:0]   stream_state_o;
  logic [LEN_W-1:0]    issued_frames_o;
  logic [POS_W-1:0]    accepted_count_o;
  logic [POS_W-1:0]    played_count_o;

  stream_scoreboard sb;
  int unsigned      words_sent;
  int unsigned      burst_left;
  int unsigned      idle_cycles;

  pcm_stream_playback_tracker i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .frame_count_i    (frame_count_i),
    .hw_position_i    (hw_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .stream_state_o   (stream_state_o),
    .issued_frames_o  (issued_frames_o),
    .accepted_count_o (accepted_count_o),
    .played_count_o   (played_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Check every result word taken by the receiver against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_report('{status_o, stream_state_o, issued_frames_o, accepted_count_o,
                        played_count_o});
    end
  end

  // Abort when no channel has moved a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver back-pressure: switch between styles after a random span
  initial begin : receiver_stalls
    int style;
    int span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 200);
      for (int i = 0; i < span; i++) begin
        @(negedge clk_i);
        case (style)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          2: out_ready_i = ($urandom_range(0, 7) != 0);
          default: out_ready_i = ((i % 24) < 16);
        endcase
      end
    end
  end

  function automatic logic [POS_W-1:0] random_pos();
    return POS_W'({$urandom(), $urandom()});
  endfunction

  // Offer one word; bursts of random length with random gaps in between.
  // Valid stays high after acceptance so the next burst word follows directly.
  task automatic send_word(logic [FUNC_W-1:0] fn, logic [FRAMES_W-1:0] frames,
                           logic [POS_W-1:0] hw);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    func_i        = fn;
    frame_count_i = frames;
    hw_position_i = hw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.log_command(fn, frames, hw);
    words_sent++;
    burst_left--;
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_all_reported();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the period only with the block idle
  task automatic write_period(logic [LEN_W-1:0] value);
    wait_all_reported();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.period = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_noise();
    logic [FRAMES_W-1:0] frames;
    frames = ($urandom_range(0, 1) == 0) ? '0 : FRAMES_W'($urandom_range(0, 256));
    send_word(FUNC_W'($urandom_range(0, 7)), frames, random_pos());
  endtask

  // Progress position: mostly at the submit cursor, sometimes short of it, ahead of it or random
  function automatic logic [POS_W-1:0] progress_pos(logic [POS_W-1:0] cursor);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return cursor;
    if (pick < 8) return cursor - POS_W'($urandom_range(0, 400));
    if (pick < 9) return cursor + POS_W'($urandom_range(0, 50));
    return random_pos();
  endfunction

  // One stream lifetime: open, traffic, optional finish and drain, then a
  // rejected word to return the block to idle; flavor 0 sends only noise words
  task automatic run_session();
    int               flavor;
    int               steps;
    int               pick;
    logic [POS_W-1:0] cursor;
    flavor = $urandom_range(0, 9);
    cursor = ($urandom_range(0, 7) == 0) ? POS_MAX - POS_W'($urandom_range(0, 20000))
                                         : POS_W'($urandom_range(0, 1000000));
    if (flavor == 0) begin
      repeat ($urandom_range(1, 6)) send_noise();
      return;
    end
    send_word(FN_OPEN, '0, random_pos());
    steps = $urandom_range(6, 40);
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 99);
      // flood flavor overfills the queue, hoard flavor retires no segments during traffic
      if (flavor == 1) pick = (pick < 85) ? 0 : 50;
      if (flavor == 2 && pick >= 65 && pick < 90) pick = 50;
      if (pick < 40) begin
        send_word(FN_DATA, ($urandom_range(0, 3) == 0) ? FRAMES_W'(256)
                                                       : FRAMES_W'($urandom_range(1, 256)),
                  random_pos());
      end else if (pick < 65) begin
        send_word(FN_SUBMIT, FRAMES_W'($urandom_range(0, 256)), cursor);
        cursor += POS_W'(sb.last_issued + $urandom_range(0, 2));
      end else if (pick < 90) begin
        send_word(FN_PROGRESS, FRAMES_W'($urandom_range(0, 256)), progress_pos(cursor));
      end else if (pick < 96) begin
        send_word(FN_QUERY, '0, random_pos());
      end else if (pick < 98) begin
        send_word(FN_CANCEL, '0, random_pos());
      end else begin
        send_noise();
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      send_word(FN_FINISH, '0, random_pos());
      for (int k = 0; k < 12 && sb.mode == MD_FINISHING; k++) begin
        send_word(FN_SUBMIT, '0, cursor);
        cursor += POS_W'(sb.last_issued);
        send_word(FN_PROGRESS, '0, cursor);
      end
    end
    case ($urandom_range(0, 3))
      0:       send_word(FN_UNUSED, '0, random_pos());
      1:       send_word(FN_QUERY, FRAMES_W'($urandom_range(1, 256)), random_pos());
      default: send_word(FN_OPEN, FRAMES_W'($urandom_range(1, 256)), random_pos());
    endcase
  endtask

  task automatic run_random(int unsigned target);
    while (words_sent < target) begin
      run_session();
      if ($urandom_range(0, 14) == 0) wait_all_reported();
    end
  endtask

  initial begin : main_flow
    logic [LEN_W-1:0] periods[7];
    sb            = new();
    words_sent    = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    func_i        = FN_QUERY;
    frame_count_i = '0;
    hw_position_i = '0;
    periods = '{LEN_W'(1), LEN_W'(4096), LEN_W'(0), LEN_W'(4095),
                LEN_W'($urandom_range(2, 300)), LEN_W'($urandom_range(1, 4096)), PERIOD_RST};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening at the reset period of 256
    send_word(FN_QUERY, '0, '0);                     // query before open
    send_word(FN_OPEN, FRAMES_W'(1), POS_MAX);       // open carrying frames
    send_word(FN_OPEN, '0, '0);
    send_word(FN_DATA, '0, '0);                      // data without frames
    send_word(FN_OPEN, '0, '0);
    send_word(FN_DATA, FRAMES_W'(257), '0);          // more than one packet
    send_word(FN_OPEN, '0, '0);
    send_word(FN_DATA, FRAMES_W'(256), POS_MAX);
    send_word(FN_DATA, FRAMES_W'(1), '0);
    send_word(FN_SUBMIT, '0, '0);                    // one full period
    send_word(FN_SUBMIT, '0, POS_MAX);               // not enough queued
    send_word(FN_PROGRESS, '0, POS_MAX);             // retire the segment
    send_word(FN_FINISH, '0, '0);
    send_word(FN_SUBMIT, FRAMES_W'(256), 48'd1000);  // remainder while finishing
    send_word(FN_PROGRESS, FRAMES_W'(256), 48'd1001); // reaches drained
    send_word(FN_DATA, FRAMES_W'(4), '0);            // data after drain
    send_word(FN_OPEN, '0, '0);
    send_word(FN_CANCEL, '0, '0);
    send_word(FN_QUERY, '0, POS_MAX);
    send_word(FN_FINISH, '0, '0);                    // finish after cancel
    send_word(FN_OPEN, '0, '0);
    send_word(FN_FINISH, '0, '0);                    // nothing accepted: drains at once
    send_word(FN_UNUSED, '0, '0);
    send_word(FN_OPEN, '0, '0);
    send_word(FN_OPEN, '0, '0);                      // already open

    run_random(PHASE_WORDS);
    foreach (periods[p]) begin
      write_period(periods[p]);
      run_random(PHASE_WORDS * (p + 2));
    end

    // Drain, let the block settle, then give the verdict
    wait_all_reported();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ pcm_stream_playback_tracker.f @@
src/pspt_pkg.sv
src/pspt_seg_ram.sv
src/pspt_seg_eval.sv
src/pcm_stream_playback_tracker.sv
dv/pcm_stream_playback_tracker_tb.sv
